FILE: src/blr_pkg.sv
// package for the bounded log ring: sizes, status and operation codes,
// register indexes and the payload byte mask; no dependencies
package blr_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int WORD_BITS   = 64;

	localparam int DATA_W  = 64;
	localparam int POS_W   = 64;
	localparam int RC_W    = 11;
	localparam int PB_W    = 4;
	localparam int SLOT_W  = $clog2(MAX_ENTRIES);
	localparam int CAP_W   = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W   = $clog2(POS_W);
	localparam int CFG_IDX_W = 2;

	typedef logic [2:0] status_t;
	typedef logic [1:0] op_t;

	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_CLOSED      = 3'd1;
	localparam status_t ST_BAD_SIZE    = 3'd2;
	localparam status_t ST_EXHAUSTED   = 3'd3;
	localparam status_t ST_FULL        = 3'd4;
	localparam status_t ST_RECLAIMED   = 3'd5;
	localparam status_t ST_UNPUBLISHED = 3'd6;
	localparam status_t ST_BAD_POS     = 3'd7;

	localparam op_t OP_PUBLISH = 2'd0;
	localparam op_t OP_VIEW    = 2'd1;
	localparam op_t OP_RECLAIM = 2'd2;
	localparam op_t OP_UNKNOWN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAY_BYTES = 2'd3;

	// keeps the low nbytes bytes of a stored word
	function automatic logic [WORD_BITS-1:0] byte_mask(input logic [PB_W-1:0] nbytes);
		logic [WORD_BITS-1:0] m;
		m = '0;
		for (int k = 0; k < WORD_BITS / 8; k++) begin
			if (k < int'(nbytes))
				m[k*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

FILE: src/blr_if.sv
// request and response channel interfaces of the bounded log ring
// depends on blr_pkg for field widths
interface blr_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                operation;
	logic [blr_pkg::DATA_W-1:0] payload_word;
	logic [blr_pkg::PB_W-1:0]   payload_len;
	logic [blr_pkg::POS_W-1:0]  log_position;

	modport source (output valid, operation, payload_word, payload_len, log_position,
		input ready);
	modport sink (input valid, operation, payload_word, payload_len, log_position,
		output ready);
endinterface

interface blr_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [blr_pkg::POS_W-1:0]  sequence_number;
	logic [blr_pkg::DATA_W-1:0] read_word;
	logic [blr_pkg::POS_W-1:0]  echo_position;

	modport source (output valid, status, sequence_number, read_word, echo_position,
		input ready);
	modport sink (input valid, status, sequence_number, read_word, echo_position,
		output ready);
endinterface

FILE: src/bounded_log_ring_top.sv
// bounded log ring: one request in, one response out, 64-bit positions
// one request at a time: a new request is taken only in idle, after the
// 64-step bit-serial pass of the last one (compares, sequence add and
// position mod capacity one bit a cycle) and its response hand-off; a response
// still stalled when the next item finishes holds that item in its last step
// reset: arst_n clears positions, exhausted flag and config to defaults;
// ring store contents are undefined until written, no clearing pass
module bounded_log_ring_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [blr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	blr_req_if.sink                       req,
	blr_rsp_if.source                     rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RUN    = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;

	localparam int SW1 = blr_pkg::SLOT_W + 1;

	logic [2:0] state_q;

	// configuration
	logic                       enabled_q;
	logic [blr_pkg::RC_W-1:0]   capacity_q;
	logic [blr_pkg::POS_W-1:0]  first_seq_q;
	logic [blr_pkg::PB_W-1:0]   pay_bytes_q;

	// log state
	logic [blr_pkg::POS_W-1:0]  head_q;
	logic [blr_pkg::POS_W-1:0]  tail_q;
	logic [blr_pkg::SLOT_W-1:0] head_slot_q;
	logic                       exhausted_q;

	// captured request
	blr_pkg::op_t               op_q;
	logic [blr_pkg::DATA_W-1:0] word_q;
	logic [blr_pkg::PB_W-1:0]   len_q;
	logic [blr_pkg::POS_W-1:0]  pos_q;
	logic [blr_pkg::CAP_W-1:0]  cap_q;

	// serial datapath
	logic [blr_pkg::CNT_W-1:0]  cnt_q;
	logic [blr_pkg::POS_W-1:0]  pos_sr_q;
	logic [blr_pkg::POS_W-1:0]  posm_sr_q;
	logic [blr_pkg::POS_W-1:0]  head_sr_q;
	logic [blr_pkg::POS_W-1:0]  tail_sr_q;
	logic [blr_pkg::POS_W-1:0]  fseq_sr_q;
	logic [blr_pkg::CAP_W-1:0]  cap_sr_q;
	logic [blr_pkg::POS_W-1:0]  seq_sr_q;
	logic [blr_pkg::POS_W-1:0]  hinc_sr_q;
	logic [blr_pkg::SLOT_W-1:0] rem_q;
	logic br_pt_q, br_ph_q, br_hp_q, br_ht_q, br_dc_q;
	logic cy_of_q, cy_seq_q, cy_inc_q;

	// result holding
	blr_pkg::status_t           res_status_q;
	logic [blr_pkg::POS_W-1:0]  res_seq_q;
	logic [blr_pkg::POS_W-1:0]  res_echo_q;
	logic                       res_view_q;

	// ring store
	logic [blr_pkg::WORD_BITS-1:0] mem [blr_pkg::MAX_ENTRIES];
	logic [blr_pkg::WORD_BITS-1:0] mem_rd_q;
	logic                          mem_we;

	// response register
	logic                       rsp_valid_q;
	blr_pkg::status_t           rsp_status_q;
	logic [blr_pkg::POS_W-1:0]  rsp_seq_q;
	logic [blr_pkg::DATA_W-1:0] rsp_word_q;
	logic [blr_pkg::POS_W-1:0]  rsp_echo_q;

	logic req_fire;
	logic rsp_free;
	logic [blr_pkg::CAP_W-1:0] cap_in_use;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.sequence_number = rsp_seq_q;
	assign rsp.read_word       = rsp_word_q;
	assign rsp.echo_position   = rsp_echo_q;

	always_comb begin
		if (capacity_q == '0)
			cap_in_use = blr_pkg::CAP_W'(1);
		else if (32'(capacity_q) > blr_pkg::MAX_ENTRIES)
			cap_in_use = blr_pkg::CAP_W'(blr_pkg::MAX_ENTRIES);
		else
			cap_in_use = blr_pkg::CAP_W'(capacity_q);
	end

	// one bit of each lsb-first serial chain; the remainder chain runs msb first
	logic b_p, b_h, b_t, b_f, b_c, b_base, b_d, b_sum, b_inc;
	logic br_pt_d, br_ph_d, br_hp_d, br_ht_d, br_dc_d, cy_of_d, cy_seq_d, cy_inc_d;
	logic [SW1-1:0] rem_sh;
	logic [SW1-1:0] cap_ext;

	always_comb begin
		b_p    = pos_sr_q[0];
		b_h    = head_sr_q[0];
		b_t    = tail_sr_q[0];
		b_f    = fseq_sr_q[0];
		b_c    = cap_sr_q[0];
		b_base = (op_q == blr_pkg::OP_PUBLISH) ? b_h : b_p;
		br_pt_d = (!b_p && b_t) || (!(b_p ^ b_t) && br_pt_q);
		br_ph_d = (!b_p && b_h) || (!(b_p ^ b_h) && br_ph_q);
		br_hp_d = (!b_h && b_p) || (!(b_h ^ b_p) && br_hp_q);
		b_d     = b_h ^ b_t ^ br_ht_q;
		br_ht_d = (!b_h && b_t) || (!(b_h ^ b_t) && br_ht_q);
		br_dc_d = (!b_d && b_c) || (!(b_d ^ b_c) && br_dc_q);
		cy_of_d = (b_h && b_f) || ((b_h ^ b_f) && cy_of_q);
		b_sum   = b_f ^ b_base ^ cy_seq_q;
		cy_seq_d = (b_f && b_base) || ((b_f ^ b_base) && cy_seq_q);
		b_inc   = b_h ^ cy_inc_q;
		cy_inc_d = b_h && cy_inc_q;
		// restoring remainder step, msb first
		cap_ext = SW1'(cap_q);
		rem_sh  = {rem_q, posm_sr_q[blr_pkg::POS_W-1]};
	end

	// decision after the serial pass
	blr_pkg::status_t dec_status;
	logic dec_pub_ok, dec_view_ok, dec_rec_ok, dec_set_exh;
	logic [SW1-1:0] slot_next;

	always_comb begin
		dec_status  = blr_pkg::ST_OK;
		dec_pub_ok  = 1'b0;
		dec_view_ok = 1'b0;
		dec_rec_ok  = 1'b0;
		dec_set_exh = 1'b0;
		if (op_q == blr_pkg::OP_UNKNOWN) begin
			dec_status = blr_pkg::ST_BAD_POS;
		end else if (!enabled_q) begin
			dec_status = blr_pkg::ST_CLOSED;
		end else if (op_q == blr_pkg::OP_PUBLISH) begin
			if (len_q != pay_bytes_q)
				dec_status = blr_pkg::ST_BAD_SIZE;
			else if (exhausted_q)
				dec_status = blr_pkg::ST_EXHAUSTED;
			else if (!br_dc_q)
				dec_status = blr_pkg::ST_FULL;
			else if (cy_of_q) begin
				dec_status  = blr_pkg::ST_EXHAUSTED;
				dec_set_exh = 1'b1;
			end else
				dec_pub_ok = 1'b1;
		end else if (op_q == blr_pkg::OP_VIEW) begin
			if (br_pt_q)
				dec_status = blr_pkg::ST_RECLAIMED;
			else if (!br_ph_q)
				dec_status = blr_pkg::ST_UNPUBLISHED;
			else
				dec_view_ok = 1'b1;
		end else begin
			if (br_pt_q || br_hp_q)
				dec_status = blr_pkg::ST_BAD_POS;
			else
				dec_rec_ok = 1'b1;
		end
		slot_next = SW1'(head_slot_q) + SW1'(1);
		if (slot_next >= SW1'(cap_q))
			slot_next = '0;
	end

	assign mem_we = (state_q == S_DECIDE) && dec_pub_ok;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[head_slot_q] <= word_q[blr_pkg::WORD_BITS-1:0]
				& blr_pkg::byte_mask(pay_bytes_q);
		if (state_q == S_DECIDE)
			mem_rd_q <= mem[rem_q];
	end

	// request capture, serial pass and decision results, datapath only
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q      <= req.operation;
			word_q    <= req.payload_word;
			len_q     <= req.payload_len;
			pos_q     <= req.log_position;
			cap_q     <= cap_in_use;
			pos_sr_q  <= req.log_position;
			posm_sr_q <= req.log_position;
			head_sr_q <= head_q;
			tail_sr_q <= tail_q;
			fseq_sr_q <= first_seq_q;
			cap_sr_q  <= cap_in_use;
			rem_q     <= '0;
			br_pt_q   <= 1'b0;
			br_ph_q   <= 1'b0;
			br_hp_q   <= 1'b0;
			br_ht_q   <= 1'b0;
			br_dc_q   <= 1'b0;
			cy_of_q   <= 1'b0;
			cy_seq_q  <= 1'b0;
			cy_inc_q  <= 1'b1;
		end else if (state_q == S_RUN) begin
			pos_sr_q  <= pos_sr_q >> 1;
			posm_sr_q <= posm_sr_q << 1;
			head_sr_q <= head_sr_q >> 1;
			tail_sr_q <= tail_sr_q >> 1;
			fseq_sr_q <= fseq_sr_q >> 1;
			cap_sr_q  <= cap_sr_q >> 1;
			seq_sr_q  <= {b_sum, seq_sr_q[blr_pkg::POS_W-1:1]};
			hinc_sr_q <= {b_inc, hinc_sr_q[blr_pkg::POS_W-1:1]};
			br_pt_q   <= br_pt_d;
			br_ph_q   <= br_ph_d;
			br_hp_q   <= br_hp_d;
			br_ht_q   <= br_ht_d;
			br_dc_q   <= br_dc_d;
			cy_of_q   <= cy_of_d;
			cy_seq_q  <= cy_seq_d;
			cy_inc_q  <= cy_inc_d;
			if (rem_sh >= cap_ext)
				rem_q <= blr_pkg::SLOT_W'(rem_sh - cap_ext);
			else
				rem_q <= blr_pkg::SLOT_W'(rem_sh);
		end
		if (state_q == S_DECIDE) begin
			res_status_q <= dec_status;
			res_view_q   <= dec_view_ok;
			res_seq_q    <= (dec_pub_ok || dec_view_ok) ? seq_sr_q : '0;
			if (dec_pub_ok)
				res_echo_q <= head_q;
			else if (dec_view_ok)
				res_echo_q <= pos_q;
			else
				res_echo_q <= '0;
		end
	end

	// control, configuration and log state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			enabled_q   <= 1'b0;
			capacity_q  <= blr_pkg::RC_W'(1024);
			first_seq_q <= blr_pkg::POS_W'(1);
			pay_bytes_q <= blr_pkg::PB_W'(8);
			head_q      <= '0;
			tail_q      <= '0;
			head_slot_q <= '0;
			exhausted_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					blr_pkg::REG_ENABLED: begin
						enabled_q <= cfg_data[0];
						if (cfg_data[0]) begin
							head_q      <= '0;
							tail_q      <= '0;
							head_slot_q <= '0;
							exhausted_q <= 1'b0;
						end
					end
					blr_pkg::REG_CAPACITY:  capacity_q  <= cfg_data[blr_pkg::RC_W-1:0];
					blr_pkg::REG_FIRST_SEQ: first_seq_q <= cfg_data[blr_pkg::POS_W-1:0];
					blr_pkg::REG_PAY_BYTES: pay_bytes_q <= cfg_data[blr_pkg::PB_W-1:0];
					default: ;
				endcase
			end

			// a new response replaces the one taken at this edge
			if (state_q == S_READ && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cnt_q   <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + blr_pkg::CNT_W'(1);
					if (cnt_q == {blr_pkg::CNT_W{1'b1}})
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (dec_set_exh)
						exhausted_q <= 1'b1;
					if (dec_pub_ok) begin
						head_q      <= hinc_sr_q;
						head_slot_q <= blr_pkg::SLOT_W'(slot_next);
					end
					if (dec_rec_ok)
						tail_q <= pos_q;
					state_q <= S_READ;
				end
				S_READ: begin
					if (rsp_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ && rsp_free) begin
			rsp_status_q <= res_status_q;
			rsp_seq_q    <= res_seq_q;
			rsp_echo_q   <= res_echo_q;
			rsp_word_q   <= res_view_q ? blr_pkg::DATA_W'(mem_rd_q) : '0;
		end
	end

endmodule

FILE: src/blr_checker.sv
// port-level checks for the bounded log ring, bound to the top level
// depends on blr_pkg and the channel interfaces of bounded_log_ring_top
module blr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [2:0]                 status,
	input logic [blr_pkg::POS_W-1:0]  sequence_number,
	input logic [blr_pkg::DATA_W-1:0] read_word,
	input logic [blr_pkg::POS_W-1:0]  echo_position
);

	// a waiting response holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(sequence_number) && $stable(read_word) && $stable(echo_position))
		else $error("response changed while stalled");

	// one request in flight: no back-to-back transactions
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// an error response carries nothing but its status
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != blr_pkg::ST_OK |->
			sequence_number == '0 && read_word == '0 && echo_position == '0)
		else $error("error response with nonzero fields");

	// only an ok response may carry a nonzero read word
	a_no_word_on_nonview: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_word != '0 |-> status == blr_pkg::ST_OK)
		else $error("read word on an error response");

endmodule

bind bounded_log_ring_top blr_checker u_blr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.sequence_number (rsp.sequence_number),
	.read_word       (rsp.read_word),
	.echo_position   (rsp.echo_position)
);
